// ===== sv/binary_to_decimal_ascii_core_defines.svh =====
// Assertion macros for the binary to decimal ASCII converter.
`ifndef BINARY_TO_DECIMAL_ASCII_CORE_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_CORE_DEFINES_SVH

// Clocked check, masked while reset is asserted.
`define BDA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define BDA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/bda_pkg.sv =====
// Constants and helper function for the binary to decimal ASCII converter.
package bda_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned NumDigits  = 10;
  localparam int unsigned DigitWidth = 4;
  localparam int unsigned BcdWidth   = NumDigits * DigitWidth;
  localparam int unsigned CharWidth  = 6;
  localparam int unsigned CntWidth   = $clog2(NumDigits + 1);
  localparam int unsigned BitCntWidth = $clog2(ValueWidth);

  localparam logic [CharWidth-1:0]  AsciiZero = CharWidth'(48);
  localparam logic [CharWidth-1:0]  AsciiNine = CharWidth'(57);
  localparam logic [DigitWidth-1:0] DigitFive = DigitWidth'(5);
  localparam logic [DigitWidth-1:0] DigitThree = DigitWidth'(3);

  // Add 3 to every BCD digit that is 5 or more, ahead of the next left shift.
  function automatic logic [BcdWidth-1:0] bcd_adjust(input logic [BcdWidth-1:0] bcd);
    logic [BcdWidth-1:0] res;
    res = bcd;
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd[i*DigitWidth +: DigitWidth] >= DigitFive) begin
        res[i*DigitWidth +: DigitWidth] = bcd[i*DigitWidth +: DigitWidth] + DigitThree;
      end
    end
    return res;
  endfunction

endpackage

// ===== sv/binary_to_decimal_ascii_core.sv =====
// Unsigned 32-bit to decimal ASCII converter, top level.
//
// Each accepted 32-bit value is converted by shift-and-add-3 (double dabble):
// one shared adjust-and-shift unit runs once per input bit. A skip phase
// then drops leading zero digits, one per cycle (up to 9), and stops at the
// first digit it keeps. The digits leave most significant first through a
// one-entry output register, one transfer per cycle while out_ready_i stays
// high; the last one has last_digit_o set. Zero gives the single digit '0'.
// in_ready_o is high only between items; the next value may be taken while
// the final digit still waits in the output register.
`include "binary_to_decimal_ascii_core_defines.svh"

module binary_to_decimal_ascii_core
  import bda_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [ValueWidth-1:0] value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [CharWidth-1:0]  digit_char_o,
  output logic                  last_digit_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StSkip = 2'd2;
  localparam logic [1:0] StEmit = 2'd3;

  localparam logic [BitCntWidth-1:0] LastBit  = BitCntWidth'(ValueWidth - 1);
  localparam logic [CntWidth-1:0]    AllDigits = CntWidth'(NumDigits);
  localparam logic [CntWidth-1:0]    OneDigit  = CntWidth'(1);

  logic [1:0]             state_q, state_d;
  logic [BitCntWidth-1:0] bit_cnt_q, bit_cnt_d;
  logic [CntWidth-1:0]    cnt_q, cnt_d;
  logic [BcdWidth-1:0]    bcd_q, bcd_d;
  logic [ValueWidth-1:0]  bin_q, bin_d;
  logic                   out_valid_q, out_valid_d;
  logic [CharWidth-1:0]   char_q, char_d;
  logic                   last_q, last_d;

  logic                   in_xfer;
  logic                   out_free;
  logic [DigitWidth-1:0]  top_digit;
  logic [BcdWidth-1:0]    bcd_adj;

  assign in_ready_o   = (state_q == StIdle);
  assign in_xfer      = in_valid_i && in_ready_o;
  assign out_free     = !out_valid_q || out_ready_i;
  assign top_digit    = bcd_q[BcdWidth-1 -: DigitWidth];
  assign bcd_adj      = bcd_adjust(bcd_q);

  assign out_valid_o  = out_valid_q;
  assign digit_char_o = char_q;
  assign last_digit_o = last_q;

  always_comb begin
    state_d     = state_q;
    bit_cnt_d   = bit_cnt_q;
    cnt_d       = cnt_q;
    bcd_d       = bcd_q;
    bin_d       = bin_q;
    out_valid_d = out_valid_q && !out_ready_i;
    char_d      = char_q;
    last_d      = last_q;
    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          bcd_d     = '0;
          bin_d     = value_i;
          bit_cnt_d = LastBit;
          state_d   = StConv;
        end
      end
      StConv: begin
        {bcd_d, bin_d} = {bcd_adj[BcdWidth-2:0], bin_q, 1'b0};
        bit_cnt_d      = bit_cnt_q - BitCntWidth'(1);
        if (bit_cnt_q == '0) begin
          cnt_d   = AllDigits;
          state_d = StSkip;
        end
      end
      StSkip: begin
        // Drop leading zeros, always keeping the units digit.
        if (top_digit == '0 && cnt_q != OneDigit) begin
          bcd_d = {bcd_q[BcdWidth-DigitWidth-1:0], {DigitWidth{1'b0}}};
          cnt_d = cnt_q - OneDigit;
        end else begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = AsciiZero + CharWidth'(top_digit);
          last_d      = (cnt_q == OneDigit);
          bcd_d       = {bcd_q[BcdWidth-DigitWidth-1:0], {DigitWidth{1'b0}}};
          cnt_d       = cnt_q - OneDigit;
          if (cnt_q == OneDigit) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      bit_cnt_q   <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_cnt_q   <= bit_cnt_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q  <= bcd_d;
    bin_q  <= bin_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  `BDA_ASSERT(a_start_conv,
    in_xfer |=> (state_q == StConv && bit_cnt_q == LastBit),
    "transfer in did not start a 32-step conversion")
  `BDA_ASSERT(a_emit_cnt,
    (state_q == StEmit || state_q == StSkip) |-> (cnt_q != '0),
    "digit count ran out while digits remain")
  `BDA_ASSERT(a_char_range,
    out_valid_o |-> (digit_char_o >= AsciiZero && digit_char_o <= AsciiNine),
    "output character is not a decimal digit")
  `BDA_ASSERT_ALWAYS(a_reset_idle,
    !rst_ni |-> (state_q == StIdle && !out_valid_o),
    "block not idle in reset")

endmodule

// ===== verif/binary_to_decimal_ascii_core_tb.sv =====
// Self-checking testbench for the binary to decimal ASCII converter.
module binary_to_decimal_ascii_core_tb
  import bda_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomValues = 100;
  localparam int unsigned HoldStart    = 1500;
  localparam int unsigned HoldCycles   = 600;
  localparam int unsigned TailCycles   = 60;

  typedef struct packed {
    logic [CharWidth-1:0] digit_char;
    logic                 last_digit;
  } digit_t;

  typedef struct {
    logic [ValueWidth-1:0] value;
    string                 text;   // empty: digits come from the predictor
  } value_row_t;

  typedef enum logic [1:0] {RxAlways, RxCoin, RxSparse, RxMostly} rx_mode_e;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i   = 1'b0;
  logic                  in_ready_o;
  logic [ValueWidth-1:0] value_i      = '0;
  logic                  out_valid_o;
  logic                  out_ready_i  = 1'b0;
  logic [CharWidth-1:0]  digit_char_o;
  logic                  last_digit_o;

  digit_t pending_digits[$];
  int     mismatches      = 0;
  int     values_sent     = 0;
  int     ten_digit_count = 0;
  int     digits_checked  = 0;
  int     longest_backoff = 0;
  int     burst_left      = 0;

  value_row_t directed_rows [19] = '{
    '{32'd0,          "0"},
    '{32'd1,          "1"},
    '{32'd9,          "9"},
    '{32'd10,         "10"},
    '{32'd99,         ""},
    '{32'd100,        ""},
    '{32'hFFFF_FFFF,  "4294967295"},
    '{32'hFFFF_FFFE,  ""},
    '{32'd999999999,  "999999999"},
    '{32'd1000000000, "1000000000"},
    '{32'h8000_0000,  "2147483648"},
    '{32'h7FFF_FFFF,  ""},
    '{32'hAAAA_AAAA,  ""},
    '{32'h5555_5555,  ""},
    '{32'd12345,      "12345"},
    '{32'd1234567890, ""},
    '{32'd7,          ""},
    '{32'd65535,      ""},
    '{32'd0,          "0"}
  };

  binary_to_decimal_ascii_core dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .value_i,
    .out_valid_o,
    .out_ready_i,
    .digit_char_o,
    .last_digit_o
  );

  always #10 clk_i = ~clk_i;

  // Decimal digits of v, most significant first, no leading zeros.
  function automatic void queue_decimal(input logic [ValueWidth-1:0] v);
    logic [DigitWidth-1:0] low_first [NumDigits];
    logic [ValueWidth-1:0] rest;
    int                    n;
    rest = v;
    n    = 0;
    do begin
      low_first[n] = DigitWidth'(rest % 10);
      rest         = rest / 10;
      n++;
    end while (rest != 0);
    for (int k = n - 1; k >= 0; k--) begin
      pending_digits.push_back('{AsciiZero + CharWidth'(low_first[k]), k == 0});
    end
    if (n == NumDigits) ten_digit_count++;
  endfunction

  function automatic void queue_text(input string text);
    for (int i = 0; i < text.len(); i++) begin
      pending_digits.push_back('{CharWidth'(text[i]), i == text.len() - 1});
    end
    if (text.len() == NumDigits) ten_digit_count++;
  endfunction

  // Hold one value on the input until the transfer, then log what it should produce.
  task automatic offer_value(input logic [ValueWidth-1:0] v, input string text);
    int waited;
    waited     = 0;
    in_valid_i <= 1'b1;
    value_i    <= v;
    do begin
      @(posedge clk_i);
      waited++;
    end while (!in_ready_o);
    if (waited > longest_backoff) longest_backoff = waited;
    if (text.len() != 0) queue_text(text);
    else queue_decimal(v);
    values_sent++;
    if (burst_left == 0) begin
      int gap;
      burst_left = $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 50);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic [ValueWidth-1:0] pick_value();
    longint unsigned lo;
    longint unsigned hi;
    int              n;
    if ($urandom_range(0, 3) == 0) return $urandom();
    n  = $urandom_range(1, NumDigits);
    lo = 1;
    for (int i = 1; i < n; i++) lo = lo * 10;
    hi = lo * 10 - 1;
    if (n == 1) lo = 0;
    if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
    return $urandom_range(ValueWidth'(hi), ValueWidth'(lo));
  endfunction

  // Output side: each digit transfer is matched against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_digits.size() == 0) begin
        $error("digit transfer with nothing expected: digit_char %0d last_digit %0b",
               digit_char_o, last_digit_o);
        mismatches++;
      end else begin
        digit_t want;
        want = pending_digits.pop_front();
        digits_checked++;
        if (digit_char_o !== want.digit_char) begin
          $error("digit_char expected %0d actual %0d", want.digit_char, digit_char_o);
          mismatches++;
        end
        if (last_digit_o !== want.last_digit) begin
          $error("last_digit expected %0b actual %0b", want.last_digit, last_digit_o);
          mismatches++;
        end
      end
    end
  end

  // Receiver: switches stall patterns now and then, with one long hold-off.
  initial begin
    rx_mode_e mode;
    int       cycle;
    mode  = RxAlways;
    cycle = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cycle++;
      if (cycle % 128 == 0) mode = rx_mode_e'($urandom_range(0, 3));
      if (cycle >= HoldStart && cycle < HoldStart + HoldCycles) begin
        out_ready_i <= 1'b0;
      end else begin
        case (mode)
          RxAlways: out_ready_i <= 1'b1;
          RxCoin:   out_ready_i <= 1'($urandom_range(0, 1));
          RxSparse: out_ready_i <= (cycle % 4 == 0);
          default:  out_ready_i <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin
    #4_000_000;
    $display("binary_to_decimal_ascii_core: mismatch");
    $finish;
  end

  initial begin
    // Falling edge at time zero so the asynchronous reset takes hold at once.
    rst_ni <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[i]) offer_value(directed_rows[i].value, directed_rows[i].text);
    for (int i = 0; i < RandomValues; i++) offer_value(pick_value(), "");
    in_valid_i <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    $display("converted %0d values (%0d of ten digits), %0d digit transfers checked",
             values_sent, ten_digit_count, digits_checked);
    $display("longest wait for an input transfer: %0d cycles", longest_backoff);
    if (mismatches == 0) begin
      $display("binary_to_decimal_ascii_core: match");
    end else begin
      $display("binary_to_decimal_ascii_core: mismatch");
    end
    $finish;
  end

endmodule
